>>> rtl/ipds_pkg.sv
// Shared constants, types and helpers for the integer PLL divider search.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package ipds_pkg;

    // Search ranges
    localparam int MULT_MIN = 25;
    localparam int MULT_MAX = 36;
    localparam int DIV_MIN  = 8;
    localparam int DIV_MAX  = 127;

    // Field widths
    localparam int XTAL_W     = 26;
    localparam int VCO_LIM_W  = 31;
    localparam int TARGET_W   = 28;
    localparam int MULT_OUT_W = 6;
    localparam int DIV_OUT_W  = 7;
    localparam int P1_W       = 18;

    // Internal widths
    localparam int MULT_W = $clog2(MULT_MAX + 1);
    localparam int DIV_W  = $clog2(DIV_MAX + 1);
    localparam int VCO_W  = XTAL_W + MULT_W;
    localparam int NUM_W  = VCO_W + 1;
    localparam int CNT_W  = $clog2(NUM_W + 1);

    // Register port
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    localparam logic [XTAL_W-1:0]    XTAL_RST    = XTAL_W'(25000000);
    localparam logic [VCO_LIM_W-1:0] VCO_MIN_RST = VCO_LIM_W'(600000000);
    localparam logic [VCO_LIM_W-1:0] VCO_MAX_RST = VCO_LIM_W'(900000000);

    typedef enum logic [1:0] {
        REG_XTAL    = 2'd0,
        REG_VCO_MIN = 2'd1,
        REG_VCO_MAX = 2'd2
    } reg_idx_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_CHK,
        S_DIV,
        S_WAIT,
        S_EVAL,
        S_DONE
    } state_t;

    typedef struct packed {
        logic init;
        logic mul;
        logic first_div;
        logic next_div;
        logic next_mult;
        logic div_start;
        logic eval;
    } cmd_t;

    typedef struct packed {
        logic target_zero;
        logic vco_ok;
        logic last_div;
        logic last_mult;
        logic div_busy;
        logic div_done;
        logic hit;
    } sts_t;

    // Packed P1 word: 128*a - 512, floored at zero
    function automatic logic [P1_W-1:0] pack_p1(input logic [11:0] a);
        logic [18:0] v;
        v = {a, 7'b0};
        return (v >= 19'd512) ? P1_W'(v - 19'd512) : '0;
    endfunction

endpackage

`default_nettype wire

>>> rtl/ipds_div.sv
// Restoring divider, one quotient bit per cycle, for the rounded output frequency.
// Depends on ipds_pkg for widths.
`default_nettype none

module ipds_div (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [ipds_pkg::NUM_W-1:0]    dividend,
    input  wire logic [ipds_pkg::DIV_W-1:0]    divisor,
    output logic                               busy,
    output logic                               done,
    output logic [ipds_pkg::NUM_W-1:0]         quot,
    output logic [ipds_pkg::DIV_W-1:0]         rem
);

    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [ipds_pkg::CNT_W-1:0]    cnt_reg, cnt_next;
    logic [ipds_pkg::NUM_W-1:0]    sh_reg, sh_next;
    logic [ipds_pkg::DIV_W-1:0]    rem_reg, rem_next;
    logic [ipds_pkg::DIV_W-1:0]    dvs_reg, dvs_next;
    logic [ipds_pkg::DIV_W:0]      trial;
    logic [ipds_pkg::DIV_W:0]      diff;
    logic                          ge;

    assign trial = {rem_reg, sh_reg[ipds_pkg::NUM_W-1]};
    assign ge    = trial >= {1'b0, dvs_reg};
    assign diff  = trial - {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        sh_next   = sh_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = ipds_pkg::CNT_W'(ipds_pkg::NUM_W);
            sh_next   = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            // shift out next dividend bit, shift in quotient bit
            sh_next  = {sh_reg[ipds_pkg::NUM_W-2:0], ge};
            rem_next = ge ? diff[ipds_pkg::DIV_W-1:0] : trial[ipds_pkg::DIV_W-1:0];
            cnt_next = cnt_reg - ipds_pkg::CNT_W'(1);
            if (cnt_reg == ipds_pkg::CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sh_reg  <= sh_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quot = sh_reg;
    assign rem  = rem_reg;

endmodule

`default_nettype wire

>>> rtl/ipds_datapath.sv
// Search datapath: multiplier and divider counters, VCO product, best-pair registers.
// Depends on ipds_pkg and ipds_div.
`default_nettype none

module ipds_datapath (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire ipds_pkg::cmd_t                    cmd,
    output ipds_pkg::sts_t                         sts,
    input  wire logic [ipds_pkg::XTAL_W-1:0]       xtal,
    input  wire logic [ipds_pkg::VCO_LIM_W-1:0]    vco_min,
    input  wire logic [ipds_pkg::VCO_LIM_W-1:0]    vco_max,
    input  wire logic [ipds_pkg::TARGET_W-1:0]     target_in,
    input  wire logic                              mode_in,
    output logic                                   found,
    output logic [ipds_pkg::MULT_OUT_W-1:0]        pll_mult,
    output logic [ipds_pkg::DIV_OUT_W-1:0]         ms_div,
    output logic [ipds_pkg::TARGET_W-1:0]          achieved_freq,
    output logic [ipds_pkg::P1_W-1:0]              pll_p1,
    output logic [ipds_pkg::P1_W-1:0]              ms_p1
);

    logic [ipds_pkg::TARGET_W-1:0]  target_reg, target_next;
    logic                           nearest_reg, nearest_next;
    logic [ipds_pkg::MULT_W-1:0]    n_reg, n_next;
    logic [ipds_pkg::DIV_W-1:0]     m_reg, m_next;
    logic [ipds_pkg::VCO_W-1:0]     vco_reg, vco_next;
    logic                           found_reg, found_next;
    logic [ipds_pkg::MULT_W-1:0]    best_n_reg, best_n_next;
    logic [ipds_pkg::DIV_W-1:0]     best_m_reg, best_m_next;
    logic [ipds_pkg::NUM_W-1:0]     best_act_reg, best_act_next;
    logic [ipds_pkg::NUM_W-1:0]     best_err_reg, best_err_next;

    logic [ipds_pkg::NUM_W-1:0]     dividend;
    logic [ipds_pkg::NUM_W-1:0]     quot;
    logic [ipds_pkg::DIV_W-1:0]     rem;
    logic [ipds_pkg::NUM_W-1:0]     tgt_ext;
    logic [ipds_pkg::NUM_W-1:0]     err;
    logic                           div_busy;
    logic                           div_done;
    logic                           hit;
    logic                           better;

    // vco + m/2, rounded division
    assign dividend = ipds_pkg::NUM_W'(vco_reg) + ipds_pkg::NUM_W'(m_reg >> 1);

    ipds_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (dividend),
        .divisor  (m_reg),
        .busy     (div_busy),
        .done     (div_done),
        .quot     (quot),
        .rem      (rem)
    );

    assign tgt_ext = ipds_pkg::NUM_W'(target_reg);
    assign err     = (quot > tgt_ext) ? (quot - tgt_ext) : (tgt_ext - quot);
    // remainder of the rounded division equals m/2 exactly when m divides vco
    assign hit     = !nearest_reg && (rem == (m_reg >> 1)) && (quot == tgt_ext);
    assign better  = nearest_reg && (!found_reg || (err < best_err_reg));

    always_comb
    begin
        target_next   = target_reg;
        nearest_next  = nearest_reg;
        n_next        = n_reg;
        m_next        = m_reg;
        vco_next      = vco_reg;
        found_next    = found_reg;
        best_n_next   = best_n_reg;
        best_m_next   = best_m_reg;
        best_act_next = best_act_reg;
        best_err_next = best_err_reg;
        if (cmd.init)
        begin
            target_next   = target_in;
            nearest_next  = mode_in;
            n_next        = ipds_pkg::MULT_W'(ipds_pkg::MULT_MIN);
            found_next    = 1'b0;
            best_n_next   = '0;
            best_m_next   = '0;
            best_act_next = '0;
            best_err_next = '0;
        end
        if (cmd.mul)
        begin
            vco_next = ipds_pkg::VCO_W'(xtal) * ipds_pkg::VCO_W'(n_reg);
        end
        if (cmd.first_div)
        begin
            m_next = ipds_pkg::DIV_W'(ipds_pkg::DIV_MIN);
        end
        if (cmd.next_div)
        begin
            m_next = m_reg + ipds_pkg::DIV_W'(2);
        end
        if (cmd.next_mult)
        begin
            n_next = n_reg + ipds_pkg::MULT_W'(1);
        end
        if (cmd.eval && (hit || better))
        begin
            found_next    = 1'b1;
            best_n_next   = n_reg;
            best_m_next   = m_reg;
            best_act_next = quot;
            best_err_next = err;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else
        begin
            found_reg <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        target_reg   <= target_next;
        nearest_reg  <= nearest_next;
        n_reg        <= n_next;
        m_reg        <= m_next;
        vco_reg      <= vco_next;
        best_n_reg   <= best_n_next;
        best_m_reg   <= best_m_next;
        best_act_reg <= best_act_next;
        best_err_reg <= best_err_next;
    end

    always_comb
    begin
        sts.target_zero = (target_reg == '0);
        sts.vco_ok      = (vco_reg >= ipds_pkg::VCO_W'(vco_min))
                          && (vco_reg <= ipds_pkg::VCO_W'(vco_max));
        sts.last_div    = (m_reg > ipds_pkg::DIV_W'(ipds_pkg::DIV_MAX - 2));
        sts.last_mult   = (n_reg == ipds_pkg::MULT_W'(ipds_pkg::MULT_MAX));
        sts.div_busy    = div_busy;
        sts.div_done    = div_done;
        sts.hit         = hit;
    end

    // saturate the achieved frequency to its field
    assign found         = found_reg;
    assign pll_mult      = ipds_pkg::MULT_OUT_W'(best_n_reg);
    assign ms_div        = ipds_pkg::DIV_OUT_W'(best_m_reg);
    assign achieved_freq = (best_act_reg > ipds_pkg::NUM_W'({ipds_pkg::TARGET_W{1'b1}}))
                           ? {ipds_pkg::TARGET_W{1'b1}}
                           : ipds_pkg::TARGET_W'(best_act_reg);
    assign pll_p1        = ipds_pkg::pack_p1(12'(best_n_reg));
    assign ms_p1         = ipds_pkg::pack_p1(12'(best_m_reg));

endmodule

`default_nettype wire

>>> rtl/ipds_ctrl.sv
// Search sequencer: walks multipliers and dividers, drives datapath commands.
// Depends on ipds_pkg.
`default_nettype none

module ipds_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire ipds_pkg::sts_t     sts,
    output ipds_pkg::cmd_t          cmd,
    output logic                    busy,
    output logic                    done
);

    ipds_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ipds_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ipds_pkg::S_IDLE:
            begin
                if (start)
                begin
                    cmd.init   = 1'b1;
                    state_next = ipds_pkg::S_MUL;
                end
            end
            ipds_pkg::S_MUL:
            begin
                cmd.mul = 1'b1;
                if (sts.target_zero)
                begin
                    state_next = ipds_pkg::S_DONE;
                end
                else
                begin
                    state_next = ipds_pkg::S_CHK;
                end
            end
            ipds_pkg::S_CHK:
            begin
                // skip a multiplier whose VCO lies outside the window
                if (sts.vco_ok)
                begin
                    cmd.first_div = 1'b1;
                    state_next    = ipds_pkg::S_DIV;
                end
                else if (sts.last_mult)
                begin
                    state_next = ipds_pkg::S_DONE;
                end
                else
                begin
                    cmd.next_mult = 1'b1;
                    state_next    = ipds_pkg::S_MUL;
                end
            end
            ipds_pkg::S_DIV:
            begin
                cmd.div_start = 1'b1;
                state_next    = ipds_pkg::S_WAIT;
            end
            ipds_pkg::S_WAIT:
            begin
                if (sts.div_done)
                begin
                    state_next = ipds_pkg::S_EVAL;
                end
            end
            ipds_pkg::S_EVAL:
            begin
                cmd.eval = 1'b1;
                if (sts.hit)
                begin
                    state_next = ipds_pkg::S_DONE;
                end
                else if (!sts.last_div)
                begin
                    cmd.next_div = 1'b1;
                    state_next   = ipds_pkg::S_DIV;
                end
                else if (sts.last_mult)
                begin
                    state_next = ipds_pkg::S_DONE;
                end
                else
                begin
                    cmd.next_mult = 1'b1;
                    state_next    = ipds_pkg::S_MUL;
                end
            end
            ipds_pkg::S_DONE:
            begin
                state_next = ipds_pkg::S_IDLE;
            end
            default:
            begin
                state_next = ipds_pkg::S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ipds_pkg::S_IDLE);
    assign done = (state_reg == ipds_pkg::S_DONE);

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held for more than one cycle");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not start a search");

    a_div_runs: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |=> (sts.div_busy && state_reg == ipds_pkg::S_WAIT))
        else $error("divider not running after start");

    a_eval_after_div: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ipds_pkg::S_EVAL) |-> $past(sts.div_done))
        else $error("evaluation without a finished division");

endmodule

`default_nettype wire

>>> rtl/integer_pll_divider_search.sv
// Top level: register port, sequencer and search datapath.
// Each multiplier/divider pair is issued, run through the 33-step divider and compared,
// after a VCO product and window check per multiplier; a full search walks 12 x 60
// pairs before the result strobe; a zero target strobes it from the product state.
// One word at a time: busy holds start off until the cycle after the one-cycle result
// strobe, which cannot be stalled. Reset (rst_n, async low) idles the sequencer and
// loads xtal 25 MHz, VCO window 600 to 900 MHz.
`default_nettype none

module integer_pll_divider_search (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [ipds_pkg::ADDR_W-1:0]          paddr,
    input  wire logic [ipds_pkg::DATA_W-1:0]          pwdata,
    output logic [ipds_pkg::DATA_W-1:0]               prdata,
    output logic                                      pready,
    input  wire logic                                 start,
    output logic                                      busy,
    input  wire logic [ipds_pkg::TARGET_W-1:0]        target_freq,
    input  wire logic                                 mode,
    output logic                                      done,
    output logic                                      found,
    output logic [ipds_pkg::MULT_OUT_W-1:0]           pll_mult,
    output logic [ipds_pkg::DIV_OUT_W-1:0]            ms_div,
    output logic [ipds_pkg::TARGET_W-1:0]             achieved_freq,
    output logic [ipds_pkg::P1_W-1:0]                 pll_p1,
    output logic [ipds_pkg::P1_W-1:0]                 ms_p1
);

    logic [ipds_pkg::XTAL_W-1:0]     xtal_reg, xtal_next;
    logic [ipds_pkg::VCO_LIM_W-1:0]  vco_min_reg, vco_min_next;
    logic [ipds_pkg::VCO_LIM_W-1:0]  vco_max_reg, vco_max_next;
    logic                            wr_en;
    ipds_pkg::reg_idx_t              idx;
    ipds_pkg::cmd_t                  cmd;
    ipds_pkg::sts_t                  sts;
    logic                            ctrl_busy;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = ipds_pkg::reg_idx_t'(paddr[3:2]);

    always_comb
    begin
        xtal_next    = xtal_reg;
        vco_min_next = vco_min_reg;
        vco_max_next = vco_max_reg;
        prdata       = '0;
        unique case (idx)
            ipds_pkg::REG_XTAL:
            begin
                prdata = ipds_pkg::DATA_W'(xtal_reg);
                if (wr_en)
                begin
                    xtal_next = pwdata[ipds_pkg::XTAL_W-1:0];
                end
            end
            ipds_pkg::REG_VCO_MIN:
            begin
                prdata = ipds_pkg::DATA_W'(vco_min_reg);
                if (wr_en)
                begin
                    vco_min_next = pwdata[ipds_pkg::VCO_LIM_W-1:0];
                end
            end
            ipds_pkg::REG_VCO_MAX:
            begin
                prdata = ipds_pkg::DATA_W'(vco_max_reg);
                if (wr_en)
                begin
                    vco_max_next = pwdata[ipds_pkg::VCO_LIM_W-1:0];
                end
            end
            default:
            begin
                // address beyond the register list: drop the write
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            xtal_reg    <= ipds_pkg::XTAL_RST;
            vco_min_reg <= ipds_pkg::VCO_MIN_RST;
            vco_max_reg <= ipds_pkg::VCO_MAX_RST;
        end
        else
        begin
            xtal_reg    <= xtal_next;
            vco_min_reg <= vco_min_next;
            vco_max_reg <= vco_max_next;
        end
    end

    ipds_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (ctrl_busy),
        .done  (done)
    );

    assign busy = ctrl_busy;

    ipds_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .xtal          (xtal_reg),
        .vco_min       (vco_min_reg),
        .vco_max       (vco_max_reg),
        .target_in     (target_freq),
        .mode_in       (mode),
        .found         (found),
        .pll_mult      (pll_mult),
        .ms_div        (ms_div),
        .achieved_freq (achieved_freq),
        .pll_p1        (pll_p1),
        .ms_p1         (ms_p1)
    );

endmodule

`default_nettype wire
